/* hw/rtl/ewtd_pkg.sv */
`timescale 1ns / 1ps

package ewtd_pkg;

  localparam int QDepth = 4;
  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);
  localparam logic [CntW-1:0] QFullCount = CntW'(QDepth);

  localparam int MaxRes = 3;
  localparam int NumSlots = 6;

  localparam logic [7:0] CharUnder = 8'h5F;
  localparam logic [7:0] CharEq = 8'h3D;
  localparam logic [7:0] CharSpace = 8'h20;

  typedef enum logic [1:0] {
    EscIdle = 2'd0,
    EscEq = 2'd1,
    EscDigit = 2'd2
  } esc_phase_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic has_byte;
    logic eow;
    logic [MaxRes-1:0][7:0] data;
  } bundle_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic [6:0] b64_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h41:8'h5A]}) begin
      d = c - 8'h41;
      return {1'b1, d[5:0]};
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = c - 8'h47;
      return {1'b1, d[5:0]};
    end else if (c inside {[8'h30:8'h39]}) begin
      d = c + 8'h04;
      return {1'b1, d[5:0]};
    end else if (c == 8'h2B) begin
      return {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      return {1'b1, 6'd63};
    end else if (c == CharEq) begin
      return {1'b1, 6'd0};
    end
    return 7'd0;
  endfunction

endpackage

/* hw/rtl/ewtd_front.sv */
`timescale 1ns / 1ps

module ewtd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              in_kind,
  input  logic [7:0]        in_char,
  input  logic              in_last_char,
  output ewtd_pkg::bundle_t bundle,
  output logic              bundle_vld
);

  ewtd_pkg::esc_phase_t esc_r, esc_nxt, q_ph;
  logic [7:0]  held_r, held_nxt, q_held;
  logic [17:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  pad_r, pad_nxt;

  logic [4:0]  hx;
  logic [4:0]  held_hx;
  logic [6:0]  bv;
  logic        run_plain;
  logic        pad_inc;
  logic [1:0]  pad_after;
  logic [23:0] grp;

  logic [ewtd_pkg::NumSlots-1:0]      slot_en;
  logic [ewtd_pkg::NumSlots-1:0][7:0] slot_val;
  logic [2:0] n;

  assign hx = ewtd_pkg::hex_value(in_char);
  assign held_hx = ewtd_pkg::hex_value(held_r);
  assign bv = ewtd_pkg::b64_value(in_char);
  assign grp = {acc_r, bv[5:0]};
  assign pad_inc = bv[6] && (in_char == ewtd_pkg::CharEq) && (cnt_r >= 2'd2) && (pad_r < 2'd2);
  assign pad_after = pad_r + {1'b0, pad_inc};

  always_comb begin
    slot_en = '0;
    slot_val = '0;
    run_plain = 1'b0;
    q_ph = ewtd_pkg::EscIdle;
    q_held = held_r;
    if (in_kind == 1'b0) begin
      case (esc_r)
        ewtd_pkg::EscEq: begin
          if (hx[4]) begin
            q_ph = ewtd_pkg::EscDigit;
            q_held = in_char;
          end else begin
            slot_en[0] = 1'b1;
            slot_val[0] = ewtd_pkg::CharEq;
            run_plain = 1'b1;
          end
        end
        ewtd_pkg::EscDigit: begin
          if (hx[4]) begin
            slot_en[2] = 1'b1;
            slot_val[2] = {held_hx[3:0], hx[3:0]};
          end else begin
            slot_en[0] = 1'b1;
            slot_val[0] = ewtd_pkg::CharEq;
            slot_en[1] = 1'b1;
            slot_val[1] = held_r;
            run_plain = 1'b1;
          end
        end
        default: begin
          run_plain = 1'b1;
        end
      endcase
      if (run_plain) begin
        if (in_char == ewtd_pkg::CharEq) begin
          q_ph = ewtd_pkg::EscEq;
        end else begin
          slot_en[3] = 1'b1;
          slot_val[3] = (in_char == ewtd_pkg::CharUnder) ? ewtd_pkg::CharSpace : in_char;
        end
      end
      if (in_last_char) begin
        if (q_ph != ewtd_pkg::EscIdle) begin
          slot_en[4] = 1'b1;
          slot_val[4] = ewtd_pkg::CharEq;
        end
        if (q_ph == ewtd_pkg::EscDigit) begin
          slot_en[5] = 1'b1;
          slot_val[5] = q_held;
        end
      end
    end else if (bv[6] && (cnt_r == 2'd3)) begin
      slot_en[0] = 1'b1;
      slot_val[0] = grp[23:16];
      slot_en[1] = (pad_after < 2'd2);
      slot_val[1] = grp[15:8];
      slot_en[2] = (pad_after == 2'd0);
      slot_val[2] = grp[7:0];
    end
  end

  always_comb begin
    n = 3'd0;
    bundle = '0;
    for (int k = 0; k < ewtd_pkg::NumSlots; k++) begin
      if (slot_en[k] && (n < 3'd3)) begin
        bundle.data[n[1:0]] = slot_val[k];
        n = n + 3'd1;
      end
    end
    bundle.eow = in_last_char;
    if (n == 3'd0) begin
      bundle.cnt = 2'd1;
      bundle.has_byte = 1'b0;
    end else begin
      bundle.cnt = n[1:0];
      bundle.has_byte = 1'b1;
    end
    bundle_vld = (n != 3'd0) || in_last_char;
  end

  always_comb begin
    esc_nxt = esc_r;
    held_nxt = held_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    pad_nxt = pad_r;
    if (in_last_char) begin
      esc_nxt = ewtd_pkg::EscIdle;
      held_nxt = 8'h00;
      acc_nxt = '0;
      cnt_nxt = 2'd0;
      pad_nxt = 2'd0;
    end else if (in_kind == 1'b0) begin
      esc_nxt = q_ph;
      held_nxt = q_held;
    end else if (bv[6]) begin
      if (cnt_r != 2'd3) begin
        acc_nxt = {acc_r[11:0], bv[5:0]};
        cnt_nxt = cnt_r + 2'd1;
        pad_nxt = pad_after;
      end else begin
        acc_nxt = '0;
        cnt_nxt = 2'd0;
        pad_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= ewtd_pkg::EscIdle;
      held_r <= 8'h00;
      acc_r <= '0;
      cnt_r <= 2'd0;
      pad_r <= 2'd0;
    end else if (accept) begin
      esc_r <= esc_nxt;
      held_r <= held_nxt;
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      pad_r <= pad_nxt;
    end
  end

endmodule

/* hw/rtl/ewtd_queue.sv */
`timescale 1ns / 1ps

module ewtd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  ewtd_pkg::bundle_t wr_data,
  input  logic              deq,
  output ewtd_pkg::bundle_t head,
  output logic              q_full,
  output logic              q_empty
);

  ewtd_pkg::bundle_t mem_r [ewtd_pkg::QDepth];
  logic [ewtd_pkg::PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [ewtd_pkg::CntW-1:0] count_r, count_nxt;
  logic do_wr, do_rd;

  assign q_full = (count_r == ewtd_pkg::QFullCount);
  assign q_empty = (count_r == '0);
  assign do_wr = wr_en && !q_full;
  assign do_rd = deq && !q_empty;
  assign head = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ewtd_pkg::QFullCount)
    else $error("Queue occupancy exceeds its depth.");

  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !q_full && !(deq && !q_empty)) |=> (count_r == $past(count_r) + 1'b1))
    else $error("Queue occupancy did not grow on a lone write.");

  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && !deq) |=> $stable(head))
    else $error("Queue head changed without a dequeue.");

endmodule

/* hw/rtl/ewtd_back.sv */
`timescale 1ns / 1ps

module ewtd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ewtd_pkg::bundle_t head,
  input  logic              q_empty,
  input  logic              pop,
  output logic              deq,
  output logic [7:0]        out_byte,
  output logic              out_has_byte,
  output logic              out_end_of_word
);

  logic [1:0] sel_r, sel_nxt;
  logic       last_sel;
  logic       take;

  assign last_sel = (sel_r == (head.cnt - 2'd1));
  assign take = pop && !q_empty;
  assign deq = take && last_sel;

  assign out_byte = head.data[sel_r];
  assign out_has_byte = head.has_byte;
  assign out_end_of_word = head.eow && last_sel;

  always_comb begin
    sel_nxt = sel_r;
    if (take) begin
      sel_nxt = last_sel ? 2'd0 : sel_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 2'd0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

/* hw/rtl/encoded_word_text_decoder.sv */
`timescale 1ns / 1ps

// A character's result group enters the queue when the character is accepted and is shown once
// it reaches the queue head. Throughput: one character per cycle while the queue is not full;
// results leave at one per cycle while pop is high, so a character that yields two or three
// bytes holds the output for that many pops; a four-entry group queue lets the input run ahead.
// Reset is synchronous and active low; it clears the decode state and empties the queue.

module encoded_word_text_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_kind,
  input  logic [7:0] in_char,
  input  logic       in_last_char,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_end_of_word
);

  ewtd_pkg::bundle_t bundle, head;
  logic bundle_vld;
  logic accept;
  logic q_full, q_empty;
  logic deq;

  assign full = q_full;
  assign empty = q_empty;
  assign accept = push && !q_full;

  ewtd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_kind     (in_kind),
    .in_char     (in_char),
    .in_last_char(in_last_char),
    .bundle      (bundle),
    .bundle_vld  (bundle_vld)
  );

  ewtd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (accept && bundle_vld),
    .wr_data(bundle),
    .deq    (deq),
    .head   (head),
    .q_full (q_full),
    .q_empty(q_empty)
  );

  ewtd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_empty        (q_empty),
    .pop            (pop),
    .deq            (deq),
    .out_byte       (out_byte),
    .out_has_byte   (out_has_byte),
    .out_end_of_word(out_end_of_word)
  );

endmodule
